>>> src/unknown_cell_neighbor_fill_unit_macros.svh
// Assertion macros for the unknown-cell neighbor fill unit
`ifndef UNKNOWN_CELL_NEIGHBOR_FILL_UNIT_MACROS_SVH
`define UNKNOWN_CELL_NEIGHBOR_FILL_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define UCNF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UCNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ucnf_pkg.sv
// Shared types and constants for the unknown-cell neighbor fill unit
package ucnf_pkg;

  localparam int CELL_W       = 8;
  localparam int GRID_WIDTH_W = 11;
  localparam int GRID_HEIGHT_W = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_UNKNOWN_CODE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST   = 11'd1024;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST  = 16'd1024;
  localparam cell_t                    UNKNOWN_CODE_RST = 8'sd51;

  typedef struct packed {
    logic push;
    logic emit;
    logic use_upper;
    logic interior;
    logic last;
  } s1_ctrl_t;

endpackage

>>> src/unknown_cell_neighbor_fill_unit.sv
// Streaming 3x3 conditional fill of unknown occupancy-grid cells
// Structure: an accepted request is registered into one compute stage, whose result is written to the output queue.
// Throughput: one request per cycle while in_ready is high, which drops as the output queue fills; each push does
// one read and one write of the line memory. A cell's result comes grid_width+1 pushes later; drains emit the rest,
// all of a one-row frame. Reset: counters, queue and registers to defaults (width 1024, height 1024, unknown code 51).
// The line memory is not cleared by reset.
`include "unknown_cell_neighbor_fill_unit_macros.svh"

module unknown_cell_neighbor_fill_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  ucnf_pkg::cell_t                   cell_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ucnf_pkg::cell_t                   out_value,
  output logic                              frame_last,
  input  logic                              cfg_write,
  input  logic [ucnf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ucnf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ucnf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  logic [GRID_WIDTH_W-1:0]  grid_width;
  logic [GRID_HEIGHT_W-1:0] grid_height;
  cell_t                    unknown_code;

  logic [WW-1:0]            weff;
  logic [GRID_HEIGHT_W-1:0] heff;

  logic [CW-1:0]            in_col;
  logic [GRID_HEIGHT_W-1:0] in_row;
  logic [CW-1:0]            out_col;
  logic [GRID_HEIGHT_W-1:0] out_row;
  logic                     input_done;

  logic in_fire, do_push, do_drain, do_emit, primed;
  logic in_col_end, in_row_end, out_col_end, out_row_end, push_last, out_last;
  logic out_interior;
  logic push_ignored;

  s1_ctrl_t s1;
  cell_t    s1_value;
  logic [CW-1:0] s1_addr;

  logic [2*CELL_W-1:0] line_mem [MAX_WIDTH];
  logic [2*CELL_W-1:0] mem_rdata;
  logic [2*CELL_W-1:0] mem_wdata;
  logic [2*CELL_W-1:0] fwd_data;
  logic [2*CELL_W-1:0] line_word;
  logic                fwd_hit;
  logic                mem_re;
  logic [CW-1:0]       mem_raddr;

  cell_t win_a [3];
  cell_t win_b [3];
  cell_t new_top, new_mid, center, result;
  logic  any_zero, fill;

  cell_t               fifo_value [FIFO_DEPTH];
  logic                fifo_last  [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]  fifo_count;
  logic                fifo_pop;

  // effective geometry
  always_comb begin
    if (grid_width == '0) begin
      weff = WW'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      weff = MAX_W;
    end else begin
      weff = WW'(grid_width);
    end
    heff = (grid_height == '0) ? GRID_HEIGHT_W'(1) : grid_height;
  end

  assign in_col_end  = (WW'(in_col) + WW'(1)) >= weff;
  assign in_row_end  = ((GRID_HEIGHT_W+1)'(in_row) + (GRID_HEIGHT_W+1)'(1))
                       >= (GRID_HEIGHT_W+1)'(heff);
  assign out_col_end = (WW'(out_col) + WW'(1)) >= weff;
  assign out_row_end = ((GRID_HEIGHT_W+1)'(out_row) + (GRID_HEIGHT_W+1)'(1))
                       >= (GRID_HEIGHT_W+1)'(heff);
  assign push_last   = in_row_end && in_col_end;
  assign out_last    = out_row_end && out_col_end;
  assign out_interior = (out_row != '0) && (out_col != '0) && !out_row_end && !out_col_end;

  assign primed = (in_row >= GRID_HEIGHT_W'(2)) ||
                  ((in_row == GRID_HEIGHT_W'(1)) && (in_col != '0));

  assign fifo_pop = out_valid && out_ready;
  assign in_ready = (fifo_count + FIFO_CW'(s1.emit)) <= FIFO_CW'(FIFO_DEPTH - 2);
  assign in_fire  = in_valid && in_ready;
  assign do_push  = in_fire && (cmd == CMD_PUSH) && !input_done;
  assign do_drain = in_fire && (cmd == CMD_DRAIN) && input_done;
  assign do_emit  = (do_push && primed) || do_drain;
  assign push_ignored = in_fire && (cmd == CMD_PUSH) && input_done;

  assign mem_re    = do_push || do_drain;
  assign mem_raddr = do_push ? in_col : out_col;

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RST;
      grid_height  <= GRID_HEIGHT_RST;
      unknown_code <= UNKNOWN_CODE_RST;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      input_done   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:   grid_width   <= cfg_data[GRID_WIDTH_W-1:0];
          REG_GRID_HEIGHT:  grid_height  <= cfg_data[GRID_HEIGHT_W-1:0];
          REG_UNKNOWN_CODE: unknown_code <= cell_t'(cfg_data[CELL_W-1:0]);
          default: ;
        endcase
      end
      if (do_push) begin
        if (push_last) begin
          in_col <= '0;
          in_row <= '0;
        end else if (in_col_end) begin
          in_col <= '0;
          in_row <= in_row + GRID_HEIGHT_W'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (do_emit) begin
        if (out_last) begin
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_end) begin
          out_col <= '0;
          out_row <= out_row + GRID_HEIGHT_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
      if (do_emit && out_last) begin
        input_done <= 1'b0;
      end else if (do_push && push_last) begin
        input_done <= 1'b1;
      end
    end
  end

  // request stage into compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1      <= '0;
      fwd_hit <= 1'b0;
    end else begin
      s1.push      <= do_push;
      s1.emit      <= do_emit;
      s1.use_upper <= !out_row_end;
      s1.interior  <= out_interior;
      s1.last      <= out_last;
      fwd_hit      <= mem_re && s1.push && (s1_addr == mem_raddr);
    end
  end

  always_ff @(posedge clk) begin
    s1_value <= cell_value;
    s1_addr  <= mem_raddr;
    fwd_data <= mem_wdata;
  end

  // line memory: upper byte two rows back, lower byte one row back
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= line_mem[mem_raddr];
    end
    if (s1.push) begin
      line_mem[s1_addr] <= mem_wdata;
    end
  end

  assign line_word = fwd_hit ? fwd_data : mem_rdata;
  assign new_top   = cell_t'(line_word[2*CELL_W-1:CELL_W]);
  assign new_mid   = cell_t'(line_word[CELL_W-1:0]);
  assign mem_wdata = {line_word[CELL_W-1:0], s1_value};

  // shift the 3x3 window by one column per push
  always_ff @(posedge clk) begin
    if (s1.push) begin
      win_a[0] <= win_b[0];
      win_a[1] <= win_b[1];
      win_a[2] <= win_b[2];
      win_b[0] <= new_top;
      win_b[1] <= new_mid;
      win_b[2] <= s1_value;
    end
  end

  always_comb begin
    if (s1.push) begin
      center = win_b[1];
    end else begin
      center = s1.use_upper ? new_top : new_mid;
    end
    any_zero = (win_a[0] == '0) || (win_a[1] == '0) || (win_a[2] == '0) ||
               (win_b[0] == '0) || (win_b[2] == '0) ||
               (new_top == '0) || (new_mid == '0) || (s1_value == '0);
    fill   = s1.push && s1.interior && (center == unknown_code) && any_zero;
    result = fill ? cell_t'(0) : center;
  end

  // output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s1.emit) begin
        wr_ptr <= wr_ptr + FIFO_PW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + FIFO_PW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(s1.emit) - FIFO_CW'(fifo_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1.emit) begin
      fifo_value[wr_ptr] <= result;
      fifo_last[wr_ptr]  <= s1.last;
    end
  end

  assign out_valid  = fifo_count != '0;
  assign out_value  = fifo_value[rd_ptr];
  assign frame_last = fifo_last[rd_ptr];

  `UCNF_ASSERT_NOW(a_queue_room, s1.emit, fifo_count < FIFO_CW'(FIFO_DEPTH), "queue overrun")
  `UCNF_ASSERT_NEXT(a_drain_emits, do_drain, s1.emit, "accepted drain produced no cell")
  `UCNF_ASSERT_NOW(a_frame_end_clears, s1.emit && s1.last, !input_done, "drain mode not cleared")
  `UCNF_ASSERT_NEXT(a_push_dropped, push_ignored, !s1.push && !s1.emit, "push during drain kept")

endmodule

>>> tb/unknown_cell_neighbor_fill_checker.sv
// Checker for the unknown-cell neighbor fill unit: predicts filled cells and compares results
module unknown_cell_neighbor_fill_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              cmd,
  input  ucnf_pkg::cell_t                   cell_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  ucnf_pkg::cell_t                   out_value,
  input  logic                              frame_last,
  input  logic                              cfg_write,
  input  logic [ucnf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ucnf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatch_count,
  output int                                cells_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ucnf_pkg::*;

  localparam int HISTORY_DEPTH = 2 * MAX_WIDTH + 3;

  typedef struct packed {
    cell_t value;
    logic  last;
  } grid_cell_result_t;

  cell_t                    cell_history [HISTORY_DEPTH];
  grid_cell_result_t        filled_cells_due [$];
  grid_cell_result_t        due_cell;
  int unsigned              in_col;
  int unsigned              out_col;
  logic [GRID_HEIGHT_W-1:0] in_row;
  logic [GRID_HEIGHT_W-1:0] out_row;
  bit                       draining;
  logic [GRID_WIDTH_W-1:0]  width_reg;
  logic [GRID_HEIGHT_W-1:0] height_reg;
  cell_t                    unknown_reg;
  int                       mismatches = 0;
  int                       cells_seen = 0;

  assign mismatch_count = mismatches;

  initial begin
    foreach (cell_history[i]) cell_history[i] = '0;
    cells_outstanding = 0;
  end

  function automatic longint grid_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return longint'(width_reg);
  endfunction

  function automatic longint grid_h();
    return (height_reg == 0) ? 1 : longint'(height_reg);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t cell %0d: %s", $realtime, cells_seen, what);
  endtask

  function automatic void emit_filled_cell();
    longint w, h, r, c, lin;
    int    dr, dc;
    cell_t center, filled;
    logic  last;
    w = grid_w();
    h = grid_h();
    r = longint'(out_row);
    c = longint'(out_col);
    lin = r * w + c;
    center = cell_history[lin % HISTORY_DEPTH];
    filled = center;
    if (r > 0 && c > 0 && r + 1 < h && c + 1 < w && center == unknown_reg) begin
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          if ((dr != 0 || dc != 0) &&
              cell_history[(lin + dr * w + dc) % HISTORY_DEPTH] == cell_t'(0)) begin
            filled = cell_t'(0);
          end
        end
      end
    end
    last = (r + 1 >= h) && (c + 1 >= w);
    filled_cells_due.push_back('{filled, last});
    if (last) begin
      out_row = '0;
      out_col = 0;
      draining = 1'b0;
    end else if (c + 1 >= w) begin
      out_col = 0;
      out_row = out_row + 1'b1;
    end else begin
      out_col = out_col + 1;
    end
  endfunction

  function automatic void advance_grid(input logic op, input cell_t value);
    longint w, h, r, c, lin, olin;
    w = grid_w();
    h = grid_h();
    if (op == CMD_DRAIN) begin
      if (draining) emit_filled_cell();
      return;
    end
    if (draining) return;
    r = longint'(in_row);
    c = longint'(in_col);
    lin = r * w + c;
    olin = longint'(out_row) * w + longint'(out_col);
    cell_history[lin % HISTORY_DEPTH] = value;
    if (r + 1 >= h && c + 1 >= w) begin
      in_row = '0;
      in_col = 0;
      draining = 1'b1;
    end else if (c + 1 >= w) begin
      in_col = 0;
      in_row = in_row + 1'b1;
    end else begin
      in_col = in_col + 1;
    end
    if (lin >= olin + w + 1) emit_filled_cell();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_col = 0;
      in_row = '0;
      out_col = 0;
      out_row = '0;
      draining = 1'b0;
      width_reg = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      unknown_reg = UNKNOWN_CODE_RST;
      filled_cells_due.delete();
      cells_outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_WIDTH:   width_reg = cfg_data[GRID_WIDTH_W-1:0];
          REG_GRID_HEIGHT:  height_reg = cfg_data[GRID_HEIGHT_W-1:0];
          REG_UNKNOWN_CODE: unknown_reg = cell_t'(cfg_data[CELL_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_grid(cmd, cell_value);
      if (out_valid && out_ready) begin
        if (filled_cells_due.size() == 0) begin
          report_mismatch($sformatf("unexpected cell value %0d last %0b",
                                    out_value, frame_last));
        end else begin
          due_cell = filled_cells_due.pop_front();
          if (out_value !== due_cell.value)
            report_mismatch($sformatf("out_value %0d, expected %0d",
                                      out_value, due_cell.value));
          if (frame_last !== due_cell.last)
            report_mismatch($sformatf("frame_last %0b, expected %0b",
                                      frame_last, due_cell.last));
        end
        cells_seen++;
      end
      cells_outstanding <= filled_cells_due.size();
    end
  end

endmodule

>>> tb/unknown_cell_neighbor_fill_unit_test.sv
// Testbench top for the unknown-cell neighbor fill unit: grid frame stimulus and verdict
module unknown_cell_neighbor_fill_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ucnf_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int RANDOM_ITEMS_PER_PHASE = 300;
  localparam int DIRECTED_GRID [9] = '{127, 0, -1, 1, -128, -128, -128, 85, 0};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  cmd_t                   cmd = CMD_PUSH;
  cell_t                  cell_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  cell_t                  out_value;
  logic                   frame_last;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatch_count;
  int                     cells_outstanding;
  int                     send_idle = 0;
  int                     recv_idle = 0;
  int                     items_sent = 0;

  unknown_cell_neighbor_fill_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .cell_value(cell_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .frame_last(frame_last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  unknown_cell_neighbor_fill_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .cell_value(cell_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .frame_last(frame_last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .cells_outstanding(cells_outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_request(input cmd_t op, input cell_t value);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    cmd <= op;
    cell_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h, input cell_t code);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= REG_UNKNOWN_CODE;
    cfg_data <= {8'($urandom), code};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic cell_t pick_cell(input cell_t code);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return code;
    if (roll < 65) return cell_t'(0);
    return cell_t'($urandom);
  endfunction

  function automatic cell_t pick_code();
    case ($urandom_range(4))
      0: return cell_t'(51);
      1: return cell_t'(0);
      2: return cell_t'(-128);
      3: return cell_t'(127);
      default: return cell_t'($urandom);
    endcase
  endfunction

  task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg, input cell_t code);
    int unsigned w_eff, h_eff, cells, drains, i;
    settle();
    write_config(w_reg, h_reg, code);
    w_eff = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    h_eff = (h_reg == 0) ? 1 : h_reg;
    cells = w_eff * h_eff;
    drains = (cells < w_eff + 1) ? cells : w_eff + 1;
    for (i = 0; i < cells; i++) begin
      if ($urandom_range(99) < 4) send_request(CMD_DRAIN, cell_t'($urandom));
      send_request(CMD_PUSH, pick_cell(code));
    end
    for (i = 0; i < drains; i++) begin
      if ($urandom_range(99) < 4) send_request(CMD_PUSH, cell_t'($urandom));
      send_request(CMD_DRAIN, cell_t'($urandom));
    end
    if ($urandom_range(99) < 20) send_request(CMD_DRAIN, cell_t'($urandom));
    items_sent += cells + drains;
  endtask

  initial begin
    int phase, start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle = 11;
    recv_idle = 54;

    send_request(CMD_DRAIN, cell_t'(0));
    settle();
    write_config(3, 3, cell_t'(-128));
    foreach (DIRECTED_GRID[i]) send_request(CMD_PUSH, cell_t'(DIRECTED_GRID[i]));
    send_request(CMD_PUSH, cell_t'(99));
    repeat (5) send_request(CMD_DRAIN, cell_t'(-1));
    settle();
    write_config(4, 1, cell_t'(127));
    send_request(CMD_PUSH, cell_t'(127));
    send_request(CMD_PUSH, cell_t'(-128));
    send_request(CMD_PUSH, cell_t'(127));
    send_request(CMD_PUSH, cell_t'(0));
    repeat (4) send_request(CMD_DRAIN, cell_t'(85));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 11;
          recv_idle = 54;
          run_frame(37, 3, cell_t'(51));
        end
        1: begin
          send_idle = 54;
          recv_idle = 11;
          run_frame(24, 1, pick_code());
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          run_frame(0, 9, pick_code());
          run_frame(5, 0, pick_code());
        end
      endcase
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS_PER_PHASE) begin
        run_frame($urandom_range(10), $urandom_range(8), pick_code());
      end
    end

    settle();
    if (mismatch_count == 0 && cells_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
